[design/assert_macros.svh]
// Assertion macros used by the blitter engine RTL.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/crfmb_pkg.sv]
// Shared constants, types and the address function of the rect fill / mono blit engine.
// No dependencies; imported by crfmb_if, the engine and the top level.
package crfmb_pkg;

    // Screen geometry and framebuffer layout
    localparam int SCREEN_WIDTH  = 256;
    localparam int SCREEN_HEIGHT = 128;
    localparam int BUFFER_COUNT  = 2;

    localparam int FIELD_W     = 12;
    localparam int CW          = FIELD_W + 1;
    localparam int X_W         = $clog2(SCREEN_WIDTH);
    localparam int XC_W        = $clog2(SCREEN_WIDTH + 1);
    localparam int Y_W         = $clog2(SCREEN_HEIGHT);
    localparam int YC_W        = $clog2(SCREEN_HEIGHT + 1);
    localparam int STORE_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT * BUFFER_COUNT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 32;
    localparam int BYTE_BITS   = 8;
    localparam int BIT_CNT_W   = $clog2(BYTE_BITS);
    localparam int RB_W        = CW - BIT_CNT_W;

    localparam logic [CW-1:0]        SW_C      = CW'(SCREEN_WIDTH);
    localparam logic [CW-1:0]        SH_C      = CW'(SCREEN_HEIGHT);
    localparam logic [BIT_CNT_W-1:0] BYTE_LAST = BIT_CNT_W'(BYTE_BITS - 1);
    localparam logic [CW-1:0]        BYTE_PAD  = CW'(BYTE_BITS - 1);

    // Configuration registers
    localparam int                   CFG_IDX_W       = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_BUFFER = CFG_IDX_W'(1);
    localparam logic [PIX_W-1:0]     DRAW_COLOR_RESET = 32'hFF171717;

    typedef enum logic [1:0] {
        CMD_FILL  = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_BYTE  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_BLIT,
        ST_READ
    } state_t;

    // Framebuffer access from the engine
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
    } mem_req_t;

    // Read completion toward the output stage
    typedef struct packed {
        logic load;
        logic zero;
    } rd_ctl_t;

    // Linear framebuffer address of pixel (x, y) in the selected buffer
    function automatic logic [ADDR_W-1:0] pix_addr(input logic buf_sel,
                                                   input logic [X_W-1:0] x,
                                                   input logic [Y_W-1:0] y);
        logic [ADDR_W-1:0] buf_idx;
        logic [ADDR_W-1:0] row_idx;
        buf_idx = (BUFFER_COUNT > 1) ? ADDR_W'(buf_sel) : '0;
        row_idx = ADDR_W'(buf_idx * ADDR_W'(SCREEN_HEIGHT)) + ADDR_W'(y);
        return ADDR_W'(row_idx * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(x);
    endfunction

endpackage

[design/crfmb_if.sv]
// Valid/ready channel interfaces for command items and pixel result items.
// Depends on crfmb_pkg for field widths.
interface crfmb_cmd_if;
    import crfmb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [FIELD_W-1:0]    pos_x;
    logic [FIELD_W-1:0]    pos_y;
    logic [FIELD_W-1:0]    span_w;
    logic [FIELD_W-1:0]    span_h;
    logic [PIX_W-1:0]      fill_color;
    logic [BYTE_BITS-1:0]  data_byte;

    modport source (output valid, cmd, pos_x, pos_y, span_w, span_h, fill_color, data_byte,
                    input ready);
    modport sink (input valid, cmd, pos_x, pos_y, span_w, span_h, fill_color, data_byte,
                  output ready);
endinterface

interface crfmb_pix_if;
    import crfmb_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, pixel_value, input ready);
    modport sink (input valid, pixel_value, output ready);
endinterface

[design/crfmb_frame_ram.sv]
// Single-port synchronous RAM holding the framebuffers, registered read data.
// No package dependency; sized by its parameters.
module crfmb_frame_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

[design/crfmb_engine.sv]
// Command sequencer: clipping, fill walk, bitmap byte expansion, read issue.
// Depends on crfmb_pkg, crfmb_if and assert_macros.svh.
`include "assert_macros.svh"

module crfmb_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    crfmb_cmd_if.sink                      cmd_ch,
    input  logic [crfmb_pkg::PIX_W-1:0]    draw_color,
    input  logic                           draw_buffer,
    input  logic                           out_free,
    output crfmb_pkg::mem_req_t            mem_req,
    output crfmb_pkg::rd_ctl_t             rd_ctl
);
    import crfmb_pkg::*;

    // Control state
    state_t                state_reg, state_next;
    logic                  blit_active_reg, blit_active_next;
    logic [X_W-1:0]        origin_x_reg, origin_x_next;
    logic [XC_W-1:0]       clip_end_x_reg, clip_end_x_next;
    logic [YC_W-1:0]       clip_end_y_reg, clip_end_y_next;
    logic [RB_W-1:0]       row_bytes_reg, row_bytes_next;
    logic [RB_W-1:0]       byte_col_reg, byte_col_next;
    logic [YC_W-1:0]       blit_row_reg, blit_row_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;

    // Working payload
    logic [X_W-1:0]        cur_x_reg, cur_x_next;
    logic [Y_W-1:0]        cur_y_reg, cur_y_next;
    logic [X_W-1:0]        start_x_reg, start_x_next;
    logic [XC_W-1:0]       end_x_reg, end_x_next;
    logic [YC_W-1:0]       end_y_reg, end_y_next;
    logic [PIX_W-1:0]      color_reg, color_next;
    logic [CW-1:0]         px_base_reg, px_base_next;
    logic [BYTE_BITS-1:0]  bits_reg, bits_next;
    logic [Y_W-1:0]        wrow_reg, wrow_next;
    logic                  rd_zero_reg, rd_zero_next;

    // Combinational helpers
    logic [CW-1:0]   sum_x, sum_y, ex_c, ey_c, w_pad;
    logic            on_screen, clip_ok;
    logic [CW-1:0]   px;
    logic [RB_W-1:0] col_inc;
    logic [YC_W-1:0] row_inc;
    logic [X_W-1:0]  addr_x;
    logic [Y_W-1:0]  addr_y;

    // Clip against the screen edges; also form the blit pixel column and the next byte and row
    always_comb
    begin
        sum_x     = CW'(cmd_ch.pos_x) + CW'(cmd_ch.span_w);
        sum_y     = CW'(cmd_ch.pos_y) + CW'(cmd_ch.span_h);
        ex_c      = (sum_x > SW_C) ? SW_C : sum_x;
        ey_c      = (sum_y > SH_C) ? SH_C : sum_y;
        w_pad     = CW'(cmd_ch.span_w) + BYTE_PAD;
        on_screen = (CW'(cmd_ch.pos_x) < SW_C) && (CW'(cmd_ch.pos_y) < SH_C);
        clip_ok   = on_screen && (cmd_ch.span_w != '0) && (cmd_ch.span_h != '0);
        px        = px_base_reg + CW'(bit_cnt_reg);
        col_inc   = byte_col_reg + 1'b1;
        row_inc   = blit_row_reg + 1'b1;
    end

    assign cmd_ch.ready = (state_reg == ST_IDLE);

    // Next state and memory requests
    always_comb
    begin
        state_next       = state_reg;
        blit_active_next = blit_active_reg;
        origin_x_next    = origin_x_reg;
        clip_end_x_next  = clip_end_x_reg;
        clip_end_y_next  = clip_end_y_reg;
        row_bytes_next   = row_bytes_reg;
        byte_col_next    = byte_col_reg;
        blit_row_next    = blit_row_reg;
        bit_cnt_next     = bit_cnt_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        start_x_next     = start_x_reg;
        end_x_next       = end_x_reg;
        end_y_next       = end_y_reg;
        color_next       = color_reg;
        px_base_next     = px_base_reg;
        bits_next        = bits_reg;
        wrow_next        = wrow_reg;
        rd_zero_next     = rd_zero_reg;
        mem_req          = '0;
        rd_ctl           = '0;
        addr_x           = cmd_ch.pos_x[X_W-1:0];
        addr_y           = cmd_ch.pos_y[Y_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_ch.valid)
                begin
                    case (cmd_t'(cmd_ch.cmd))
                        CMD_FILL:
                        begin
                            if (clip_ok)
                            begin
                                start_x_next = cmd_ch.pos_x[X_W-1:0];
                                cur_x_next   = cmd_ch.pos_x[X_W-1:0];
                                cur_y_next   = cmd_ch.pos_y[Y_W-1:0];
                                end_x_next   = XC_W'(ex_c);
                                end_y_next   = YC_W'(ey_c);
                                color_next   = cmd_ch.fill_color;
                                state_next   = ST_FILL;
                            end
                        end
                        CMD_BEGIN:
                        begin
                            // Open a bitmap, or close any open one when ignored
                            if (clip_ok)
                            begin
                                origin_x_next    = cmd_ch.pos_x[X_W-1:0];
                                clip_end_x_next  = XC_W'(ex_c);
                                clip_end_y_next  = YC_W'(ey_c);
                                row_bytes_next   = w_pad[CW-1:BIT_CNT_W];
                                byte_col_next    = '0;
                                blit_row_next    = YC_W'(cmd_ch.pos_y);
                                blit_active_next = 1'b1;
                            end
                            else
                            begin
                                blit_active_next = 1'b0;
                            end
                        end
                        CMD_BYTE:
                        begin
                            if (blit_active_reg)
                            begin
                                px_base_next = CW'(origin_x_reg)
                                             + CW'({byte_col_reg, {BIT_CNT_W{1'b0}}});
                                bits_next    = cmd_ch.data_byte;
                                bit_cnt_next = '0;
                                wrow_next    = blit_row_reg[Y_W-1:0];
                                color_next   = draw_color;
                                state_next   = ST_BLIT;
                                // Advance the byte position; close after the last row
                                if (col_inc >= row_bytes_reg)
                                begin
                                    byte_col_next = '0;
                                    blit_row_next = row_inc;
                                    if (row_inc >= clip_end_y_reg)
                                    begin
                                        blit_active_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    byte_col_next = col_inc;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            mem_req.re   = on_screen;
                            rd_zero_next = !on_screen;
                            state_next   = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                // Write one pixel, then step across the row and down
                addr_x        = cur_x_reg;
                addr_y        = cur_y_reg;
                mem_req.we    = 1'b1;
                mem_req.wdata = color_reg;
                if (XC_W'(cur_x_reg) + 1'b1 == end_x_reg)
                begin
                    cur_x_next = start_x_reg;
                    if (YC_W'(cur_y_reg) + 1'b1 == end_y_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cur_y_next = cur_y_reg + 1'b1;
                    end
                end
                else
                begin
                    cur_x_next = cur_x_reg + 1'b1;
                end
            end
            ST_BLIT:
            begin
                // One bit per cycle, MSB first; set bits inside the clip write
                addr_x        = px[X_W-1:0];
                addr_y        = wrow_reg;
                mem_req.we    = bits_reg[BYTE_BITS-1] && (px < CW'(clip_end_x_reg));
                mem_req.wdata = color_reg;
                bits_next     = {bits_reg[BYTE_BITS-2:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BYTE_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                // Hand the read data to the output stage once it has room
                if (out_free)
                begin
                    rd_ctl.load = 1'b1;
                    rd_ctl.zero = rd_zero_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        mem_req.addr = pix_addr(draw_buffer, addr_x, addr_y);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            blit_active_reg <= 1'b0;
            origin_x_reg    <= '0;
            clip_end_x_reg  <= '0;
            clip_end_y_reg  <= '0;
            row_bytes_reg   <= '0;
            byte_col_reg    <= '0;
            blit_row_reg    <= '0;
            bit_cnt_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            blit_active_reg <= blit_active_next;
            origin_x_reg    <= origin_x_next;
            clip_end_x_reg  <= clip_end_x_next;
            clip_end_y_reg  <= clip_end_y_next;
            row_bytes_reg   <= row_bytes_next;
            byte_col_reg    <= byte_col_next;
            blit_row_reg    <= blit_row_next;
            bit_cnt_reg     <= bit_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        start_x_reg <= start_x_next;
        end_x_reg   <= end_x_next;
        end_y_reg   <= end_y_next;
        color_reg   <= color_next;
        px_base_reg <= px_base_next;
        bits_reg    <= bits_next;
        wrow_reg    <= wrow_next;
        rd_zero_reg <= rd_zero_next;
    end

    `ASSERT_IMPLIES(a_wr_only_drawing, clk, rst_n, mem_req.we, (state_reg == ST_FILL) || (state_reg == ST_BLIT), "framebuffer write outside a drawing state")
    `ASSERT_IMPLIES(a_fill_in_clip, clk, rst_n, state_reg == ST_FILL, (XC_W'(cur_x_reg) < end_x_reg) && (YC_W'(cur_y_reg) < end_y_reg), "fill walk left its clipped rectangle")
    `ASSERT_IMPLIES(a_blit_row_open, clk, rst_n, blit_active_reg, blit_row_reg < clip_end_y_reg, "open bitmap past its last clipped row")
    `ASSERT_NEXT(a_read_follows, clk, rst_n, cmd_ch.valid && cmd_ch.ready && (cmd_ch.cmd == CMD_READ), state_reg == ST_READ, "read item did not start a read")
endmodule

[design/clipped_rect_fill_and_mono_blit_top.sv]
// A read issues on acceptance; the RAM registers the data and the output stage loads it once
// it has room. Fill writes each clipped pixel; a bitmap byte writes its set bits MSB first;
// begin and ignored items complete on acceptance. One item is worked at a time, paced by the
// single framebuffer write port. A waiting result does not block fill, begin or byte items.
// Reset (rst_n, async active low) clears control state, closes any bitmap and restores
// draw_color and draw_buffer; framebuffer contents are undefined until written.
module clipped_rect_fill_and_mono_blit_top (
    input  logic                               clk,
    input  logic                               rst_n,
    crfmb_cmd_if.sink                          cmd_ch,
    crfmb_pix_if.source                        pix_ch,
    input  logic                               cfg_we,
    input  logic [crfmb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crfmb_pkg::PIX_W-1:0]        cfg_data
);
    import crfmb_pkg::*;

    logic [PIX_W-1:0] draw_color_reg, draw_color_next;
    logic             draw_buffer_reg, draw_buffer_next;
    logic             pix_valid_reg, pix_valid_next;
    logic [PIX_W-1:0] pixel_reg, pixel_next;
    logic             out_free;
    logic [PIX_W-1:0] ram_rdata;
    mem_req_t         mem_req;
    rd_ctl_t          rd_ctl;

    // Command sequencer
    crfmb_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_ch      (cmd_ch),
        .draw_color  (draw_color_reg),
        .draw_buffer (draw_buffer_reg),
        .out_free    (out_free),
        .mem_req     (mem_req),
        .rd_ctl      (rd_ctl)
    );

    // Framebuffer storage
    crfmb_frame_ram #(
        .DATA_W (PIX_W),
        .ADDR_W (ADDR_W)
    ) u_frame_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (ram_rdata)
    );

    // Configuration writes
    always_comb
    begin
        draw_color_next  = draw_color_reg;
        draw_buffer_next = draw_buffer_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DRAW_COLOR:  draw_color_next  = cfg_data;
                CFG_DRAW_BUFFER: draw_buffer_next = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Output stage: hold the result until taken
    always_comb
    begin
        out_free       = !pix_valid_reg || pix_ch.ready;
        pix_valid_next = pix_valid_reg && !pix_ch.ready;
        pixel_next     = pixel_reg;
        if (rd_ctl.load)
        begin
            pix_valid_next = 1'b1;
            pixel_next     = rd_ctl.zero ? '0 : ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_color_reg  <= DRAW_COLOR_RESET;
            draw_buffer_reg <= 1'b0;
            pix_valid_reg   <= 1'b0;
        end
        else
        begin
            draw_color_reg  <= draw_color_next;
            draw_buffer_reg <= draw_buffer_next;
            pix_valid_reg   <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign pix_ch.valid       = pix_valid_reg;
    assign pix_ch.pixel_value = pixel_reg;
endmodule
